[src/bra_pkg.sv]
`default_nettype none

package bra_pkg;

    localparam int MAP_WORDS_DEF = 64;
    localparam int WORD_BITS_DEF = 64;

    localparam int ACTION_W = 2;
    localparam int START_W  = 12;
    localparam int COUNT_W  = 13;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 12;

    localparam logic [ACTION_W-1:0] ACT_RESERVE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SET     = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_RUN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAME   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BOUNDS = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_WRITE,
        S_DONE
    } bra_state_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  index;
    } bra_res_t;

endpackage

`default_nettype wire

[src/bitmap_run_allocator_top.sv]
// first-fit run allocator over an occupancy bitmap (1 = used)
// input channel s_*: one request per transfer, action / start_index / count
//   action 0 reserves a run of count free bits, 1 marks a range used,
//   2 marks a range free; code 3 is a no-op answered with status ok
// output channel m_*: exactly one result per request, status and index
//   status 0 ok, 1 no free run, 2 bit already in target state, 3 out of bounds
// the bitmap sits in one word-wide ram read one word per cycle
// reserve: scans the words up to the one where the run completes,
//   then writes each word the run covers
// set and clear: one pass from word 0 to the last word of the range to check,
//   a second pass to write
// after reset the ram is cleared one word per cycle;
//   s_tready stays low until that pass ends
// results sit in an output register; a stalled receiver holds m_tdata and
//   the block still takes and works on the next request, stalling only when
//   a second result is ready before the first transfer
`default_nettype none

module bitmap_run_allocator_top import bra_pkg::*; #(
    parameter int MAP_WORDS = MAP_WORDS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // action[1:0], start_index[13:2], count[26:14]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata   // status[1:0], index[13:2]
);

    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic                 res_valid, res_ready;
    bra_res_t             res;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata, mem_rdata;
    logic                 m_tvalid_reg, m_tvalid_next;
    bra_res_t             out_reg, out_next;

    bra_ctrl #(
        .MAP_WORDS (MAP_WORDS),
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .action      (s_tdata[1:0]),
        .start_index (s_tdata[13:2]),
        .count       (s_tdata[26:14]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    bra_mem #(
        .MAP_WORDS (MAP_WORDS),
        .WORD_BITS (WORD_BITS)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
            if (res_valid) begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_reg.index, out_reg.status};

endmodule

`default_nettype wire

[src/bra_mem.sv]
`default_nettype none

module bra_mem import bra_pkg::*; #(
    parameter int MAP_WORDS = MAP_WORDS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF,
    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
    input  wire logic                 aclk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        waddr,
    input  wire logic [WORD_BITS-1:0] wdata,
    input  wire logic [AW-1:0]        raddr,
    output logic      [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [MAP_WORDS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/bra_ctrl.sv]
`default_nettype none

module bra_ctrl import bra_pkg::*; #(
    parameter int MAP_WORDS = MAP_WORDS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF,
    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [ACTION_W-1:0]  action,
    input  wire logic [START_W-1:0]   start_index,
    input  wire logic [COUNT_W-1:0]   count,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output bra_res_t                  res,
    output logic                      mem_we,
    output logic      [AW-1:0]        mem_waddr,
    output logic      [WORD_BITS-1:0] mem_wdata,
    output logic      [AW-1:0]        mem_raddr,
    input  wire logic [WORD_BITS-1:0] mem_rdata
);

    localparam int TOTAL = MAP_WORDS * WORD_BITS;
    localparam int TB    = $clog2(TOTAL + 1);
    localparam int SW    = (TB > COUNT_W + 1) ? TB : COUNT_W + 1;
    localparam int PW    = $clog2(WORD_BITS + 1);
    localparam int KB    = PW;
    localparam logic [AW-1:0] LAST_W = AW'(MAP_WORDS - 1);
    localparam logic [SW-1:0] TOTAL_S = SW'(TOTAL);
    localparam logic [SW-1:0] WB_S    = SW'(WORD_BITS);

    bra_state_t state_reg, state_next;
    logic [AW-1:0]       w_reg, w_next;
    logic [SW-1:0]       base_reg, base_next;
    logic [SW-1:0]       lo_reg, lo_next;
    logic [SW-1:0]       hi_reg, hi_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic                tgt_reg, tgt_next;
    logic [SW-1:0]       run_reg, run_next;
    logic [SW-1:0]       run_start_reg, run_start_next;
    logic [AW-1:0]       run_w_reg, run_w_next;
    logic [SW-1:0]       run_base_reg, run_base_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [INDEX_W-1:0]  index_reg, index_next;

    function automatic logic [PW-1:0] clamp_off(input logic [SW-1:0] v,
                                                input logic [SW-1:0] b);
        logic [SW:0] top;
        logic [SW-1:0] diff;
        top  = {1'b0, b} + {1'b0, WB_S};
        diff = v - b;
        if (v <= b) begin
            return '0;
        end else if ({1'b0, v} >= top) begin
            return PW'(WORD_BITS);
        end else begin
            return diff[PW-1:0];
        end
    endfunction

    function automatic logic [WORD_BITS-1:0] therm(input logic [PW-1:0] n);
        logic [WORD_BITS-1:0] m;
        for (int p = 0; p < WORD_BITS; p++) begin
            m[p] = (PW'(p) < n);
        end
        return m;
    endfunction

    // per-word datapath
    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS:0]   pwx [KB];
    logic [WORD_BITS:0]   acc;
    logic [PW-1:0]        lowz, topz, pend;
    logic                 any_end;
    logic [KB-1:0]        cw;
    logic [WORD_BITS-1:0] mask;
    logic                 conflict;
    logic [SW:0]          cross_sum;
    logic [SW:0]          base_top;
    logic                 range_last;
    logic [SW-1:0]        cnt_s;

    always_comb begin
        free_bits = ~mem_rdata;
        cnt_s     = SW'(cnt_reg);
        cw        = cnt_reg[KB-1:0];
        pwx[0]    = {free_bits, 1'b0};
        for (int k = 0; k < KB - 1; k++) begin
            pwx[k+1] = pwx[k] & (pwx[k] << (1 << k));
        end
        acc = '1;
        for (int k = 0; k < KB; k++) begin
            if (cw[k]) begin
                acc = pwx[k] & (acc << (1 << k));
            end
        end
        any_end = (cnt_s <= WB_S) && (|acc[WORD_BITS:1]);
        pend = '0;
        for (int p = WORD_BITS - 1; p >= 0; p--) begin
            if (acc[p+1]) begin
                pend = PW'(p);
            end
        end
        lowz = PW'(WORD_BITS);
        for (int p = WORD_BITS - 1; p >= 0; p--) begin
            if (mem_rdata[p]) begin
                lowz = PW'(p);
            end
        end
        topz = PW'(WORD_BITS);
        for (int p = 0; p < WORD_BITS; p++) begin
            if (mem_rdata[p]) begin
                topz = PW'(WORD_BITS - 1 - p);
            end
        end
        cross_sum  = {1'b0, run_reg} + (SW + 1)'(lowz);
        mask       = therm(clamp_off(hi_reg, base_reg)) & ~therm(clamp_off(lo_reg, base_reg));
        conflict   = tgt_reg ? |(mem_rdata & mask) : |(~mem_rdata & mask);
        base_top   = {1'b0, base_reg} + {1'b0, WB_S};
        range_last = (w_reg == LAST_W) || (base_top >= {1'b0, hi_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            w_reg     <= '0;
        end else begin
            state_reg <= state_next;
            w_reg     <= w_next;
        end
        base_reg      <= base_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        cnt_reg       <= cnt_next;
        tgt_reg       <= tgt_next;
        run_reg       <= run_next;
        run_start_reg <= run_start_next;
        run_w_reg     <= run_w_next;
        run_base_reg  <= run_base_next;
        status_reg    <= status_next;
        index_reg     <= index_next;
    end

    logic [SW-1:0] start_s, sum_s, lo_tmp;

    always_comb begin
        state_next     = state_reg;
        w_next         = w_reg;
        base_next      = base_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        cnt_next       = cnt_reg;
        tgt_next       = tgt_reg;
        run_next       = run_reg;
        run_start_next = run_start_reg;
        run_w_next     = run_w_reg;
        run_base_next  = run_base_reg;
        status_next    = status_reg;
        index_next     = index_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        mem_we         = 1'b0;
        mem_wdata      = mem_rdata;
        start_s        = SW'(start_index);
        sum_s          = start_s + SW'(count);
        lo_tmp         = '0;

        unique case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (w_reg == LAST_W) begin
                    w_next     = '0;
                    state_next = S_IDLE;
                end else begin
                    w_next = w_reg + AW'(1);
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    status_next = ST_OK;
                    index_next  = '0;
                    cnt_next    = count;
                    w_next      = '0;
                    base_next   = '0;
                    run_next    = '0;
                    priority if (action == ACT_RESERVE) begin
                        if (count == '0 || SW'(count) > TOTAL_S) begin
                            status_next = ST_NO_RUN;
                            state_next  = S_DONE;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end else if (action == ACT_SET || action == ACT_CLEAR) begin
                        tgt_next = (action == ACT_SET);
                        lo_next  = start_s;
                        hi_next  = sum_s;
                        if (sum_s > TOTAL_S) begin
                            status_next = ST_BOUNDS;
                            state_next  = S_DONE;
                        end else if (count == '0) begin
                            state_next = S_DONE;
                        end else begin
                            state_next = S_CHECK;
                        end
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                tgt_next = 1'b1;
                if (cross_sum >= {1'b0, cnt_s}) begin
                    if (run_reg == '0) begin
                        lo_tmp    = base_reg;
                        w_next    = w_reg;
                        base_next = base_reg;
                    end else begin
                        lo_tmp    = run_start_reg;
                        w_next    = run_w_reg;
                        base_next = run_base_reg;
                    end
                    lo_next    = lo_tmp;
                    hi_next    = lo_tmp + cnt_s;
                    index_next = lo_tmp[INDEX_W-1:0];
                    state_next = S_WRITE;
                end else if (any_end) begin
                    lo_tmp     = base_reg + SW'(pend) + SW'(1) - cnt_s;
                    lo_next    = lo_tmp;
                    hi_next    = lo_tmp + cnt_s;
                    index_next = lo_tmp[INDEX_W-1:0];
                    w_next     = w_reg;
                    base_next  = base_reg;
                    state_next = S_WRITE;
                end else if (w_reg == LAST_W) begin
                    status_next = ST_NO_RUN;
                    state_next  = S_DONE;
                end else begin
                    if (mem_rdata == '0) begin
                        if (run_reg == '0) begin
                            run_start_next = base_reg;
                            run_w_next     = w_reg;
                            run_base_next  = base_reg;
                        end
                        run_next = run_reg + WB_S;
                    end else begin
                        run_next       = SW'(topz);
                        run_start_next = base_reg + WB_S - SW'(topz);
                        run_w_next     = w_reg;
                        run_base_next  = base_reg;
                    end
                    w_next    = w_reg + AW'(1);
                    base_next = base_reg + WB_S;
                end
            end
            S_CHECK: begin
                if (conflict) begin
                    status_next = ST_SAME;
                    state_next  = S_DONE;
                end else if (range_last) begin
                    w_next     = '0;
                    base_next  = '0;
                    state_next = S_WRITE;
                end else begin
                    w_next    = w_reg + AW'(1);
                    base_next = base_reg + WB_S;
                end
            end
            S_WRITE: begin
                mem_we    = 1'b1;
                mem_wdata = tgt_reg ? (mem_rdata | mask) : (mem_rdata & ~mask);
                if (range_last) begin
                    state_next = S_DONE;
                end else begin
                    w_next    = w_reg + AW'(1);
                    base_next = base_reg + WB_S;
                end
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign mem_waddr  = w_reg;
    assign mem_raddr  = w_next;
    assign res.status = status_reg;
    assign res.index  = index_reg;

endmodule

`default_nettype wire
